### hw/rtl/rdsm_pkg.sv
// Shared constants and types for the dot-star regular expression matcher.
`default_nettype none

package rdsm_pkg;

   localparam int MAX_TOKENS_DEFAULT = 32;

   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOT  = 8'h2E;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_TEXT   = 2'd2,
      FUNC_END    = 2'd3
   } func_type;

endpackage

`default_nettype wire

### hw/rtl/regex_dot_star_matcher.sv
// An end-of-text transaction moves from the input register to the result register.
// Throughput: one transaction per cycle except when stalled as described below; the
// pattern store and active-position set update in a single pass between the input
// register and the result register. The result register stalls the input side only
// when it holds an untaken result and an end-of-text transaction waits behind it.
// Reset (synchronous, active high) empties the pattern, clears the error flag and
// leaves only the start position active; token storage itself is not reset.
`default_nettype none

module regex_dot_star_matcher #(
   parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_in
   input  wire logic [1:0] req_tuser,   // [1:0] func
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] matched, [1] pattern_error, [7:2] zero
);
   import rdsm_pkg::*;

   localparam int NPOS  = MAX_TOKENS + 1;
   localparam int CNT_W = $clog2(MAX_TOKENS + 1);
   localparam int IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

   // carry-style prefix closure: position j is live if some live position i <= j
   // reaches it by skipping only starred tokens
   function automatic logic [NPOS-1:0] close_set(input logic [NPOS-1:0] act,
                                                 input logic [NPOS-1:0] skip);
      logic [NPOS-1:0] g;
      logic [NPOS-1:0] p;
      logic [NPOS-1:0] g_lvl;
      logic [NPOS-1:0] p_lvl;
      g = act;
      p = skip;
      for (int d = 1; d < NPOS; d = d * 2) begin
         g_lvl = g;
         p_lvl = p;
         for (int j = d; j < NPOS; j++) begin
            g[j] = g_lvl[j] | (p_lvl[j] & g_lvl[j-d]);
            p[j] = p_lvl[j] & p_lvl[j-d];
         end
      end
      return g;
   endfunction

   // input register
   logic            s1_valid_ff, s1_valid_in;
   func_type        s1_func_ff;
   logic [7:0]      s1_char_ff;

   // pattern and matcher state
   logic [7:0]      token_byte_ff    [MAX_TOKENS];
   logic            token_starred_ff [MAX_TOKENS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic            bad_ff, bad_in;
   logic [NPOS-1:0] active_ff, active_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            matched_ff, error_ff;

   logic            s1_move;
   logic            req_accept;
   logic [MAX_TOKENS-1:0] in_use;
   logic [NPOS-1:0] skip;
   logic [NPOS-1:0] closed;
   logic [NPOS-1:0] stay;
   logic [NPOS-1:0] adv;
   logic [NPOS-1:0] nxt;
   logic [CNT_W-1:0] count_dec;
   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] wr_idx;
   logic            wr_token;
   logic            set_star;
   logic            end_match;

   assign s1_move    = s1_valid_ff &&
                       ((s1_func_ff != FUNC_END) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   assign count_dec = count_ff - CNT_W'(1);
   assign last_idx  = count_dec[IDX_W-1:0];
   assign wr_idx    = count_ff[IDX_W-1:0];

   always_comb begin
      in_use = '0;
      skip   = '0;
      stay   = '0;
      adv    = '0;
      for (int k = 0; k < MAX_TOKENS; k++) begin
         in_use[k]  = CNT_W'(k) < count_ff;
         skip[k+1]  = in_use[k] & token_starred_ff[k];
      end
      closed = close_set(active_ff, skip);
      for (int k = 0; k < MAX_TOKENS; k++) begin
         if (closed[k] && in_use[k] &&
             (token_byte_ff[k] == CH_DOT || token_byte_ff[k] == s1_char_ff)) begin
            stay[k]  = token_starred_ff[k];
            adv[k+1] = !token_starred_ff[k];
         end
      end
      nxt       = stay | adv;
      end_match = closed[count_ff] && !bad_ff;
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_token     = 1'b0;
      set_star     = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         s1_valid_in = 1'b0;
         unique case (s1_func_ff)
            FUNC_CLEAR: begin
               count_in  = '0;
               bad_in    = 1'b0;
               active_in = NPOS'(1);
            end
            FUNC_APPEND: begin
               active_in = NPOS'(1);
               if (s1_char_ff == CH_STAR) begin
                  if (count_ff == '0 || token_starred_ff[last_idx]) begin
                     bad_in = 1'b1;
                  end else begin
                     set_star = 1'b1;
                  end
               end else if (count_ff >= CNT_W'(MAX_TOKENS)) begin
                  bad_in = 1'b1;
               end else begin
                  wr_token = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FUNC_TEXT: begin
               active_in = nxt;
            end
            FUNC_END: begin
               active_in    = NPOS'(1);
               rsp_valid_in = 1'b1;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         active_ff    <= NPOS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and token storage, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff <= func_type'(req_tuser);
         s1_char_ff <= req_tdata;
      end
      if (wr_token) begin
         token_byte_ff[wr_idx]    <= s1_char_ff;
         token_starred_ff[wr_idx] <= 1'b0;
      end
      if (set_star) begin
         token_starred_ff[last_idx] <= 1'b1;
      end
      if (s1_move && s1_func_ff == FUNC_END) begin
         matched_ff <= end_match;
         error_ff   <= bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, error_ff, matched_ff};

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the dot-star regular expression matcher.
`timescale 1ns / 1ps

module tb;
   import rdsm_pkg::*;

   localparam int MAX_TOK = MAX_TOKENS_DEFAULT;
   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic pattern_error;
      logic matched;
   } verdict_type;

   class match_scoreboard;
      logic [7:0] pat_byte [MAX_TOK];
      logic pat_star [MAX_TOK];
      int unsigned pat_len;
      logic [MAX_TOK:0] live;
      logic bad;
      verdict_type verdicts [$];
      int errors;

      function new();
         pat_len = 0;
         bad = 1'b0;
         live = 1;
         errors = 0;
         foreach (pat_byte[k]) begin
            pat_byte[k] = 8'h00;
            pat_star[k] = 1'b0;
         end
      endfunction

      // Let every starred token be skipped; walk upward so skips chain.
      function logic [MAX_TOK:0] closed_live();
         logic [MAX_TOK:0] set;
         set = live;
         for (int k = 0; k < pat_len; k++) begin
            if (set[k] && pat_star[k]) set[k+1] = 1'b1;
         end
         return set;
      endfunction

      function void note_item(func_type f, logic [7:0] ch);
         logic [MAX_TOK:0] cur;
         logic [MAX_TOK:0] nxt;
         verdict_type v;
         case (f)
            FUNC_CLEAR: begin
               pat_len = 0;
               bad = 1'b0;
               live = 1;
            end
            FUNC_APPEND: begin
               if (ch == CH_STAR) begin
                  if (pat_len == 0 || pat_star[pat_len-1]) bad = 1'b1;
                  else pat_star[pat_len-1] = 1'b1;
               end else if (pat_len >= MAX_TOK) begin
                  bad = 1'b1;
               end else begin
                  pat_byte[pat_len] = ch;
                  pat_star[pat_len] = 1'b0;
                  pat_len++;
               end
               live = 1;
            end
            FUNC_TEXT: begin
               cur = closed_live();
               nxt = '0;
               for (int k = 0; k < pat_len; k++) begin
                  if (cur[k] && (pat_byte[k] == CH_DOT || pat_byte[k] == ch)) begin
                     if (pat_star[k]) nxt[k] = 1'b1;
                     else nxt[k+1] = 1'b1;
                  end
               end
               live = nxt;
            end
            default: begin
               cur = closed_live();
               v.matched = cur[pat_len] && !bad;
               v.pattern_error = bad;
               verdicts.push_back(v);
               live = 1;
            end
         endcase
      endfunction

      function void check_result(logic [7:0] data);
         verdict_type v;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, data);
            errors++;
            return;
         end
         v = verdicts.pop_front();
         if (data[0] !== v.matched) begin
            $display("%0t: matched mismatch, expected %b, actual %b",
                     $time, v.matched, data[0]);
            errors++;
         end
         if (data[1] !== v.pattern_error) begin
            $display("%0t: pattern_error mismatch, expected %b, actual %b",
                     $time, v.pattern_error, data[1]);
            errors++;
         end
         if (data[7:2] !== 6'd0) begin
            $display("%0t: padding mismatch, expected 0, actual %h", $time, data[7:2]);
            errors++;
         end
      endfunction

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_in
   logic [1:0] req_tuser = FUNC_CLEAR;   // [1:0] func
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // [0] matched, [1] pattern_error, [7:2] zero

   match_scoreboard board = new();
   int items_sent = 0;
   int cycles = 0;
   int burst_left = 0;
   int seq_index = 0;

   regex_dot_star_matcher uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Sample between edges: a transaction seen here completes at the next rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_item(func_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   // Mostly short gaps, a few long ones, with occasional runs of no gap at all.
   function int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(func_type f, logic [7:0] ch);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= ch;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_pattern_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 8'h61 + 8'(r);
      if (r < 5) return CH_DOT;
      if (r < 9) return 8'h61 + 8'($urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   // One pattern, then a few texts built mostly to fit it.
   task automatic run_sequence();
      logic [7:0] tok_byte [$];
      logic tok_star [$];
      logic [7:0] text [$];
      logic [7:0] ch;
      int n_tok;
      int reps;
      int pos;
      if ($urandom_range(0, 9) != 0) send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
      n_tok = (seq_index % 12 == 5) ? $urandom_range(30, 36) : $urandom_range(0, 6);
      seq_index++;
      for (int i = 0; i < n_tok; i++) begin
         ch = pick_pattern_char();
         if ($urandom_range(0, 39) == 0) send_item(FUNC_APPEND, CH_STAR);
         send_item(FUNC_APPEND, ch);
         if (ch != CH_STAR) begin
            tok_byte.push_back(ch);
            tok_star.push_back(1'b0);
            if ($urandom_range(0, 2) == 0) begin
               send_item(FUNC_APPEND, CH_STAR);
               tok_star[tok_star.size()-1] = 1'b1;
            end
         end
      end
      repeat ($urandom_range(1, 4)) begin
         text.delete();
         foreach (tok_byte[i]) begin
            reps = tok_star[i] ? $urandom_range(0, 3) : 1;
            repeat (reps) begin
               text.push_back(tok_byte[i] == CH_DOT ? 8'($urandom_range(0, 255))
                                                    : tok_byte[i]);
            end
         end
         // Break the text now and then: change, insert or drop one byte.
         if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text.size());
            case ($urandom_range(0, 2))
               0: if (pos < text.size()) text[pos] = 8'($urandom_range(0, 255));
               1: text.insert(pos, 8'($urandom_range(0, 255)));
               default: if (pos < text.size()) text.delete(pos);
            endcase
         end
         foreach (text[i]) begin
            if ($urandom_range(0, 29) == 0) begin
               send_item(func_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            send_item(FUNC_TEXT, text[i]);
         end
         send_item(FUNC_END, 8'($urandom_range(0, 255)));
      end
   endtask

   // Receiver: random stalls, plus one long hold-off so the result register fills.
   initial begin
      int on_len;
      int off_len;
      bit held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && items_sent >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            on_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
            rsp_tready <= 1'b1;
            repeat (on_len) @(posedge clock);
            off_len = pick_gap();
            if (off_len > 0) begin
               rsp_tready <= 1'b0;
               repeat (off_len) @(posedge clock);
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern against empty text.
      send_item(FUNC_END, 8'h00);
      // Leading star.
      send_item(FUNC_CLEAR, 8'hFF);
      send_item(FUNC_APPEND, CH_STAR);
      send_item(FUNC_END, 8'hFF);
      // Double star.
      send_item(FUNC_CLEAR, 8'h00);
      send_item(FUNC_APPEND, 8'h61);
      send_item(FUNC_APPEND, CH_STAR);
      send_item(FUNC_APPEND, CH_STAR);
      send_item(FUNC_END, 8'h00);
      // Wildcard star, extreme bytes, star and dot as text.
      send_item(FUNC_CLEAR, 8'h00);
      send_item(FUNC_APPEND, CH_DOT);
      send_item(FUNC_APPEND, CH_STAR);
      send_item(FUNC_APPEND, 8'hFF);
      send_item(FUNC_TEXT, CH_STAR);
      send_item(FUNC_TEXT, CH_DOT);
      send_item(FUNC_TEXT, 8'h00);
      send_item(FUNC_TEXT, 8'hFF);
      send_item(FUNC_END, 8'h00);
      // Edit the pattern mid-text: earlier text is forgotten.
      send_item(FUNC_TEXT, 8'h5A);
      send_item(FUNC_APPEND, 8'h62);
      send_item(FUNC_TEXT, 8'hFF);
      send_item(FUNC_TEXT, 8'h62);
      send_item(FUNC_END, 8'hFF);
      // A dot in the text does not match a literal token.
      send_item(FUNC_CLEAR, 8'h00);
      send_item(FUNC_APPEND, 8'h61);
      send_item(FUNC_TEXT, CH_DOT);
      send_item(FUNC_END, 8'h00);

      while (items_sent < ITEM_TARGET) run_sequence();

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/rdsm_pkg.sv
hw/rtl/regex_dot_star_matcher.sv
sim/tb.sv
